// File: src/turtle_recovery_sequencer_core_defines.svh
// Assertion macros for the turtle recovery sequencer.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef TURTLE_RECOVERY_SEQUENCER_CORE_DEFINES_SVH
`define TURTLE_RECOVERY_SEQUENCER_CORE_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define TRS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the next cycle after the antecedent
`define TRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/trs_pkg.sv
// Shared types and constants for the turtle recovery sequencer.
// No dependencies; used by trs_cfg_regs, trs_step and the top level.
package trs_pkg;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_START  = 4'b0010,
    ST_ROTATE = 4'b0100,
    ST_EXIT   = 4'b1000
  } stage_t;

  // stage codes as reported on the result channel
  localparam logic [1:0] STAGE_IDLE   = 2'd0;
  localparam logic [1:0] STAGE_START  = 2'd1;
  localparam logic [1:0] STAGE_ROTATE = 2'd2;
  localparam logic [1:0] STAGE_EXIT   = 2'd3;

  // register indexes (address bit 2)
  localparam logic REG_THROTTLE = 1'b0;
  localparam logic REG_TIMEOUT  = 1'b1;

  localparam logic [31:0] TIMEOUT_RST = 32'd1000000;
  localparam logic [6:0]  PCT_MAX     = 7'd100;
  // pct*16384/100 = (pct*ceil(2^24/25)) >> 12, exact for pct <= 100
  localparam logic [19:0] RECIP_25    = 20'd671089;

  localparam logic [16:0] MAG_HALF   = 17'd8192;
  localparam logic [14:0] GZ_HALF    = 15'd8192;
  localparam logic [15:0] Q_POS_ONE  = 16'h4000;
  localparam logic [15:0] Q_NEG_ONE  = 16'hC000;

  typedef struct packed {
    logic        cmd;
    logic        on_ground;
    logic [15:0] gravity_z;
    logic [15:0] roll_stick;
    logic [15:0] pitch_stick;
    logic [31:0] now_us;
  } item_t;

  typedef struct packed {
    logic [14:0] thr_q;
    logic [31:0] timeout_us;
  } cfg_t;

  typedef struct packed {
    logic        ready;
    stage_t      stage;
    logic        last_ground;
    logic        axis_pitch;
    logic        dir_positive;
    logic [31:0] start_time;
    logic        reverse;
    logic        ctrl;
    logic        motor;
    logic [15:0] ov_roll;
    logic [15:0] ov_pitch;
    logic [14:0] ov_thr;
  } state_t;

  localparam state_t STATE_RST = '{
    ready:        1'b0,
    stage:        ST_IDLE,
    last_ground:  1'b0,
    axis_pitch:   1'b0,
    dir_positive: 1'b0,
    start_time:   32'd0,
    reverse:      1'b0,
    ctrl:         1'b0,
    motor:        1'b0,
    ov_roll:      16'd0,
    ov_pitch:     16'd0,
    ov_thr:       15'd0
  };

  function automatic logic [1:0] stage_code(input stage_t s);
    logic [1:0] c;
    case (s)
      ST_IDLE:   c = STAGE_IDLE;
      ST_START:  c = STAGE_START;
      ST_ROTATE: c = STAGE_ROTATE;
      ST_EXIT:   c = STAGE_EXIT;
      default:   c = STAGE_IDLE;
    endcase
    return c;
  endfunction

endpackage

// File: src/trs_cfg_regs.sv
// APB-style register file: throttle percent and rotation timeout.
// Depends on trs_pkg; keeps the scaled throttle value precomputed.
module trs_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output trs_pkg::cfg_t     cfg
);

  logic [6:0]  pct_r, pct_nxt;
  logic [14:0] thr_r, thr_nxt;
  logic [31:0] tmo_r, tmo_nxt;
  logic        wr_en;
  logic [6:0]  pct_sat;
  logic [26:0] thr_prod;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // saturate to 100 % and scale to Q1.14 by reciprocal multiply
  assign pct_sat  = (pwdata[6:0] > trs_pkg::PCT_MAX) ? trs_pkg::PCT_MAX : pwdata[6:0];
  assign thr_prod = 27'(pct_sat) * 27'(trs_pkg::RECIP_25);

  always_comb begin
    pct_nxt = pct_r;
    thr_nxt = thr_r;
    tmo_nxt = tmo_r;
    if (wr_en) begin
      case (paddr[2])
        trs_pkg::REG_THROTTLE: begin
          pct_nxt = pwdata[6:0];
          thr_nxt = thr_prod[26:12];
        end
        trs_pkg::REG_TIMEOUT: begin
          tmo_nxt = pwdata;
        end
        default: begin
          tmo_nxt = tmo_r;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      trs_pkg::REG_THROTTLE: prdata = {25'd0, pct_r};
      trs_pkg::REG_TIMEOUT:  prdata = tmo_r;
      default:               prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= 7'd0;
      thr_r <= 15'd0;
      tmo_r <= trs_pkg::TIMEOUT_RST;
    end else begin
      pct_r <= pct_nxt;
      thr_r <= thr_nxt;
      tmo_r <= tmo_nxt;
    end
  end

  assign cfg.thr_q      = thr_r;
  assign cfg.timeout_us = tmo_r;

endmodule

// File: src/trs_step.sv
// Next-state logic for one sequencer step (start request or periodic step).
// Depends on trs_pkg; purely combinational.
module trs_step (
  input  trs_pkg::state_t cur,
  input  trs_pkg::item_t  item,
  input  trs_pkg::cfg_t   cfg,
  output trs_pkg::state_t nxt
);

  logic [16:0]      roll_ext, pitch_ext;
  logic [16:0]      roll_mag, pitch_mag;
  logic             roll_pos, pitch_pos;
  logic             gz_neg, gz_up;
  logic             trigger;
  logic [31:0]      elapsed;
  trs_pkg::stage_t  work;

  assign roll_ext  = {item.roll_stick[15], item.roll_stick};
  assign pitch_ext = {item.pitch_stick[15], item.pitch_stick};
  assign roll_mag  = roll_ext[16]  ? (17'd0 - roll_ext)  : roll_ext;
  assign pitch_mag = pitch_ext[16] ? (17'd0 - pitch_ext) : pitch_ext;
  assign roll_pos  = !item.roll_stick[15]  && (item.roll_stick != 16'd0);
  assign pitch_pos = !item.pitch_stick[15] && (item.pitch_stick != 16'd0);
  assign gz_neg    = item.gravity_z[15];
  assign gz_up     = !item.gravity_z[15] && (item.gravity_z[14:0] > trs_pkg::GZ_HALF);
  assign elapsed   = item.now_us - cur.start_time;
  // armed edge: ground flag falls
  assign trigger   = (item.on_ground != cur.last_ground) && !item.on_ground;

  always_comb begin
    nxt  = cur;
    work = cur.stage;
    if (item.cmd) begin
      if (!cur.ready && item.on_ground) begin
        nxt.ready = 1'b1;
        nxt.stage = trs_pkg::ST_IDLE;
      end
    end else if (!cur.ready) begin
      if (cur.stage != trs_pkg::ST_IDLE) begin
        nxt.reverse = 1'b0;
      end
      nxt.stage = trs_pkg::ST_IDLE;
      nxt.ctrl  = 1'b0;
      nxt.motor = 1'b0;
    end else begin
      nxt.last_ground = item.on_ground;
      if (gz_neg && trigger) begin
        work = trs_pkg::ST_START;
      end
      if (gz_up) begin
        work = trs_pkg::ST_EXIT;
      end
      nxt.stage = work;
      case (work)
        trs_pkg::ST_START: begin
          nxt.ctrl         = 1'b1;
          nxt.motor        = 1'b1;
          nxt.reverse      = 1'b1;
          nxt.ov_roll      = 16'd0;
          nxt.ov_pitch     = 16'd0;
          nxt.ov_thr       = 15'd0;
          nxt.axis_pitch   = 1'b0;
          nxt.dir_positive = 1'b0;
          if ((roll_mag > trs_pkg::MAG_HALF) || (pitch_mag > trs_pkg::MAG_HALF)) begin
            // ties go to roll
            if (roll_mag < pitch_mag) begin
              nxt.axis_pitch   = 1'b1;
              nxt.dir_positive = pitch_pos;
            end else begin
              nxt.dir_positive = roll_pos;
            end
            nxt.stage      = trs_pkg::ST_ROTATE;
            nxt.start_time = item.now_us;
          end
        end
        trs_pkg::ST_ROTATE: begin
          nxt.ov_thr = cfg.thr_q;
          if (cur.axis_pitch) begin
            nxt.ov_pitch = cur.dir_positive ? trs_pkg::Q_POS_ONE : trs_pkg::Q_NEG_ONE;
          end else begin
            nxt.ov_roll  = cur.dir_positive ? trs_pkg::Q_POS_ONE : trs_pkg::Q_NEG_ONE;
          end
          // upright case already diverted to exit above
          if (elapsed > cfg.timeout_us) begin
            nxt.stage = trs_pkg::ST_START;
          end
        end
        trs_pkg::ST_EXIT: begin
          nxt.ready   = 1'b0;
          nxt.stage   = trs_pkg::ST_IDLE;
          nxt.ctrl    = 1'b0;
          nxt.motor   = 1'b0;
          nxt.reverse = 1'b0;
        end
        default: begin
          nxt.stage = work;
        end
      endcase
    end
  end

endmodule

// File: src/turtle_recovery_sequencer_core.sv
// Channel   Direction  Handshake               Beat contents
// in_*      input      in_valid / in_stall     cmd, ground, gravity z, sticks, time
// out_*     output     out_valid / out_stall   stage, flags, override values
// apb       input      psel/penable/pready     throttle percent, timeout
//
// One beat accepted per cycle while in_stall is low; a beat goes into the input register,
// then through the step logic into the state/result register, loaded with out_valid.
// The state registers double as the result register: they only change when
// a beat moves into the output, so a stalled result holds.
// Synchronous active-low reset clears all control state and the overrides.
// in_stall rises only while the input register is full and the output is stalled.
// Top level of the turtle recovery sequencer; uses trs_pkg, trs_cfg_regs, trs_step.
`include "turtle_recovery_sequencer_core_defines.svh"

module turtle_recovery_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic        in_on_ground,
  input  logic signed [15:0] in_gravity_z,
  input  logic signed [15:0] in_roll_stick,
  input  logic signed [15:0] in_pitch_stick,
  input  logic [31:0] in_now_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_stage,
  output logic        out_armed_ready,
  output logic        out_pilot_override,
  output logic        out_motor_test_override,
  output logic        out_reverse_drive,
  output logic signed [15:0] out_override_roll,
  output logic signed [15:0] out_override_pitch,
  output logic signed [15:0] out_override_yaw,
  output logic [14:0] out_override_throttle,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  trs_pkg::item_t  item_r, item_nxt;
  logic            s1_v_r, s1_v_nxt;
  logic            out_v_r, out_v_nxt;
  trs_pkg::state_t state_r, state_nxt;
  trs_pkg::cfg_t   cfg;
  logic            out_adv, s1_go, in_take;

  trs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  trs_step u_step (
    .cur  (state_r),
    .item (item_r),
    .cfg  (cfg),
    .nxt  (state_nxt)
  );

  assign out_adv  = !out_v_r || !out_stall;
  assign s1_go    = s1_v_r && out_adv;
  assign in_stall = s1_v_r && !out_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    item_nxt.cmd         = in_cmd;
    item_nxt.on_ground   = in_on_ground;
    item_nxt.gravity_z   = in_gravity_z;
    item_nxt.roll_stick  = in_roll_stick;
    item_nxt.pitch_stick = in_pitch_stick;
    item_nxt.now_us      = in_now_us;
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_take) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_go) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= trs_pkg::STATE_RST;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (s1_go) begin
        state_r <= state_nxt;
      end
    end
  end

  assign out_valid               = out_v_r;
  assign out_stage               = trs_pkg::stage_code(state_r.stage);
  assign out_armed_ready         = state_r.ready;
  assign out_pilot_override      = state_r.ctrl;
  assign out_motor_test_override = state_r.motor;
  assign out_reverse_drive       = state_r.reverse;
  assign out_override_roll       = state_r.ov_roll;
  assign out_override_pitch      = state_r.ov_pitch;
  assign out_override_yaw        = 16'sd0;
  assign out_override_throttle   = state_r.ov_thr;

  `TRS_ASSERT_ALWAYS(a_no_exit_held, state_r.stage != trs_pkg::ST_EXIT, "exit stage was stored")
  `TRS_ASSERT_ALWAYS(a_flags_need_ready, !(state_r.ctrl || state_r.motor) || state_r.ready, "override flag set while not armed")
  `TRS_ASSERT_ALWAYS(a_stage_needs_ready, (state_r.stage == trs_pkg::ST_IDLE) || state_r.ready, "active stage while not armed")
  `TRS_ASSERT_NEXT(a_state_holds_on_stall, out_v_r && out_stall, $stable(state_r), "state moved under a stalled result")

endmodule

// File: sim/tb_turtle_recovery_sequencer_core.sv
// Self-checking testbench for turtle_recovery_sequencer_core: directed and random beats,
// a scoreboard class that predicts every result, and APB register setup per phase.
// Depends on trs_pkg and the RTL of the block.
`timescale 1ns / 100ps

localparam int Q_HALF_LEVEL = 8192;
localparam int Q_ONE_LEVEL  = 16384;

typedef struct packed {
  logic [1:0]  stage;
  logic        armed;
  logic        ctrl;
  logic        motor;
  logic        reverse;
  logic [15:0] roll;
  logic [15:0] pitch;
  logic [15:0] yaw;
  logic [14:0] thr;
} recovery_result_t;

class recovery_scoreboard;
  logic        armed_q;
  logic        last_gnd;
  logic        on_pitch;
  logic        dir_pos;
  logic        reverse_on;
  logic        ctrl_on;
  logic        motor_on;
  logic [1:0]  stage;
  logic [31:0] rot_start;
  logic [15:0] ov_roll;
  logic [15:0] ov_pitch;
  logic [15:0] ov_yaw;
  logic [14:0] ov_thr;
  logic [6:0]  thr_pct;
  logic [31:0] rot_timeout;
  recovery_result_t expected_q[$];
  int errors;

  function new();
    armed_q = 0;
    last_gnd = 0;
    on_pitch = 0;
    dir_pos = 0;
    reverse_on = 0;
    ctrl_on = 0;
    motor_on = 0;
    stage = trs_pkg::STAGE_IDLE;
    rot_start = '0;
    ov_roll = '0;
    ov_pitch = '0;
    ov_yaw = '0;
    ov_thr = '0;
    thr_pct = '0;
    rot_timeout = trs_pkg::TIMEOUT_RST;
    errors = 0;
  endfunction

  function int magnitude(logic [15:0] v);
    int s;
    s = $signed(v);
    return (s < 0) ? -s : s;
  endfunction

  function void note_input(trs_pkg::item_t it);
    int gz;
    int mr;
    int mp;
    int pct_sat;
    logic trigger;
    logic [31:0] elapsed;
    recovery_result_t r;
    gz = $signed(it.gravity_z);
    mr = magnitude(it.roll_stick);
    mp = magnitude(it.pitch_stick);
    trigger = 0;
    if (it.cmd) begin
      // start request only takes effect when disarmed on the ground
      if (!armed_q && it.on_ground) begin
        armed_q = 1;
        stage = trs_pkg::STAGE_IDLE;
      end
    end else if (!armed_q) begin
      if (stage != trs_pkg::STAGE_IDLE) reverse_on = 0;
      stage = trs_pkg::STAGE_IDLE;
      ctrl_on = 0;
      motor_on = 0;
    end else begin
      if (it.on_ground != last_gnd) begin
        last_gnd = it.on_ground;
        trigger = !it.on_ground;
      end
      if (gz < 0 && trigger) stage = trs_pkg::STAGE_START;
      if (gz > Q_HALF_LEVEL) stage = trs_pkg::STAGE_EXIT;
      case (stage)
        trs_pkg::STAGE_START: begin
          ctrl_on = 1;
          motor_on = 1;
          reverse_on = 1;
          ov_roll = '0;
          ov_pitch = '0;
          ov_yaw = '0;
          ov_thr = '0;
          on_pitch = 0;
          dir_pos = 0;
          if (mr > Q_HALF_LEVEL || mp > Q_HALF_LEVEL) begin
            // ties go to roll
            if (mr < mp) begin
              on_pitch = 1;
              dir_pos = ($signed(it.pitch_stick) > 0);
            end else begin
              dir_pos = ($signed(it.roll_stick) > 0);
            end
            stage = trs_pkg::STAGE_ROTATE;
            rot_start = it.now_us;
          end
        end
        trs_pkg::STAGE_ROTATE: begin
          pct_sat = (thr_pct > trs_pkg::PCT_MAX) ? int'(trs_pkg::PCT_MAX) : int'(thr_pct);
          ov_thr = 15'((pct_sat * Q_ONE_LEVEL) / 100);
          if (on_pitch) ov_pitch = dir_pos ? trs_pkg::Q_POS_ONE : trs_pkg::Q_NEG_ONE;
          else ov_roll = dir_pos ? trs_pkg::Q_POS_ONE : trs_pkg::Q_NEG_ONE;
          elapsed = it.now_us - rot_start;
          if (elapsed > rot_timeout) stage = trs_pkg::STAGE_START;
          if (gz > Q_HALF_LEVEL) stage = trs_pkg::STAGE_EXIT;
        end
        trs_pkg::STAGE_EXIT: begin
          armed_q = 0;
          stage = trs_pkg::STAGE_IDLE;
          ctrl_on = 0;
          motor_on = 0;
          reverse_on = 0;
        end
        default: ;
      endcase
    end
    r.stage = stage;
    r.armed = armed_q;
    r.ctrl = ctrl_on;
    r.motor = motor_on;
    r.reverse = reverse_on;
    r.roll = ov_roll;
    r.pitch = ov_pitch;
    r.yaw = ov_yaw;
    r.thr = ov_thr;
    expected_q.push_back(r);
  endfunction

  function void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(recovery_result_t got);
    recovery_result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: result beat with nothing expected, actual %h", $time, got);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    compare_field("stage", 16'(want.stage), 16'(got.stage));
    compare_field("armed_ready", 16'(want.armed), 16'(got.armed));
    compare_field("pilot_override", 16'(want.ctrl), 16'(got.ctrl));
    compare_field("motor_test_override", 16'(want.motor), 16'(got.motor));
    compare_field("reverse_drive", 16'(want.reverse), 16'(got.reverse));
    compare_field("override_roll", want.roll, got.roll);
    compare_field("override_pitch", want.pitch, got.pitch);
    compare_field("override_yaw", want.yaw, got.yaw);
    compare_field("override_throttle", 16'(want.thr), 16'(got.thr));
  endfunction
endclass

module tb_turtle_recovery_sequencer_core;
  localparam int IDLE_LIMIT = 1000;
  localparam int HOLD_CYCLES = 40;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd;
  logic        in_on_ground;
  logic [15:0] in_gravity_z;
  logic [15:0] in_roll_stick;
  logic [15:0] in_pitch_stick;
  logic [31:0] in_now_us;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_stage;
  logic        out_armed_ready;
  logic        out_pilot_override;
  logic        out_motor_test_override;
  logic        out_reverse_drive;
  logic [15:0] out_override_roll;
  logic [15:0] out_override_pitch;
  logic [15:0] out_override_yaw;
  logic [14:0] out_override_throttle;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  recovery_scoreboard sb;
  recovery_result_t   seen_result;
  logic [31:0] now_t;
  logic [31:0] time_span;
  int          item_count;
  int          idle_cycles;
  bit          gaps_on;
  bit          stalls_on;
  bit          pressure_hold;

  turtle_recovery_sequencer_core uut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_cmd                  (in_cmd),
    .in_on_ground            (in_on_ground),
    .in_gravity_z            (in_gravity_z),
    .in_roll_stick           (in_roll_stick),
    .in_pitch_stick          (in_pitch_stick),
    .in_now_us               (in_now_us),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_stage               (out_stage),
    .out_armed_ready         (out_armed_ready),
    .out_pilot_override      (out_pilot_override),
    .out_motor_test_override (out_motor_test_override),
    .out_reverse_drive       (out_reverse_drive),
    .out_override_roll       (out_override_roll),
    .out_override_pitch      (out_override_pitch),
    .out_override_yaw        (out_override_yaw),
    .out_override_throttle   (out_override_throttle),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // random field values
  function automatic int rand_stick();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  function automatic int small_stick();
    return int'($urandom_range(0, 16384)) - 8192;
  endfunction

  function automatic int big_stick();
    int v;
    v = int'($urandom_range(8193, 16384));
    return $urandom_range(0, 1) ? v : -v;
  endfunction

  function automatic int gz_any();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int gz_low();
    return int'($urandom_range(0, 40960)) - 32768;
  endfunction

  function automatic int gz_neg();
    return -int'($urandom_range(1, 32768));
  endfunction

  function automatic int gz_up();
    return int'($urandom_range(8193, 32767));
  endfunction

  function automatic logic [31:0] next_time();
    if ($urandom_range(0, 15) == 0) now_t = $urandom;
    else now_t = now_t + $urandom_range(0, time_span);
    return now_t;
  endfunction

  task automatic drive_item(input trs_pkg::item_t it);
    if (gaps_on && !pressure_hold && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid       <= 1;
    in_cmd         <= it.cmd;
    in_on_ground   <= it.on_ground;
    in_gravity_z   <= it.gravity_z;
    in_roll_stick  <= it.roll_stick;
    in_pitch_stick <= it.pitch_stick;
    in_now_us      <= it.now_us;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    item_count++;
  endtask

  task automatic send_beat(input logic cmd, input logic gnd, input int gz, input int roll,
                           input int pitch, input logic [31:0] now);
    trs_pkg::item_t it;
    it.cmd = cmd;
    it.on_ground = gnd;
    it.gravity_z = 16'(gz);
    it.roll_stick = 16'(roll);
    it.pitch_stick = 16'(pitch);
    it.now_us = now;
    drive_item(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel    <= 0;
    penable <= 0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] pct_word, input logic [31:0] tmo);
    drain();
    cfg_write({trs_pkg::REG_THROTTLE, 2'b00}, pct_word);
    cfg_write({trs_pkg::REG_TIMEOUT, 2'b00}, tmo);
    sb.thr_pct = pct_word[6:0];
    sb.rot_timeout = tmo;
    time_span = (tmo > 32'd2000000) ? 32'd1000000 : tmo / 2 + 3;
  endtask

  // one recovery attempt: arm, ground, lift-off inverted, wait, rotate, upright
  task automatic run_recovery();
    int r;
    int p;
    send_beat(1, $urandom_range(0, 9) != 0, gz_any(), rand_stick(), rand_stick(), next_time());
    repeat ($urandom_range(1, 2))
      send_beat(0, 1, gz_any(), rand_stick(), rand_stick(), next_time());
    send_beat(0, 0, ($urandom_range(0, 4) != 0) ? gz_neg() : gz_any(), small_stick(),
              small_stick(), next_time());
    repeat ($urandom_range(0, 3))
      send_beat(0, 0, gz_low(), small_stick(), small_stick(), next_time());
    case ($urandom_range(0, 4))
      0: begin
        r = big_stick();
        p = $urandom_range(0, 1) ? r : -r;
      end
      1, 2: begin
        r = big_stick();
        p = rand_stick();
      end
      default: begin
        p = big_stick();
        r = rand_stick();
      end
    endcase
    send_beat(0, 0, gz_low(), r, p, next_time());
    repeat ($urandom_range(2, 10))
      send_beat(0, $urandom_range(0, 9) == 0, ($urandom_range(0, 9) == 0) ? gz_any() : gz_low(),
                rand_stick(), rand_stick(), next_time());
    send_beat(0, $urandom_range(0, 1), gz_up(), rand_stick(), rand_stick(), next_time());
  endtask

  task automatic run_phase(input logic [31:0] pct_word, input logic [31:0] tmo,
                           input int n_items);
    int stop_at;
    set_config(pct_word, tmo);
    stop_at = item_count + n_items;
    while (item_count < stop_at) begin
      if ($urandom_range(0, 3) != 0) begin
        run_recovery();
      end else begin
        repeat ($urandom_range(1, 4))
          send_beat($urandom_range(0, 1), $urandom_range(0, 1), gz_any(), rand_stick(),
                    rand_stick(), next_time());
      end
    end
  endtask

  // receiver side
  initial begin
    out_stall <= 0;
    forever begin
      @(posedge clk);
      if (pressure_hold) begin
        out_stall <= 1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 0;
        pressure_hold = 0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_result = {out_stage, out_armed_ready, out_pilot_override,
                     out_motor_test_override, out_reverse_drive, out_override_roll,
                     out_override_pitch, out_override_yaw, out_override_throttle};
      sb.check_result(seen_result);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("turtle_recovery_sequencer_core test failed");
      $finish;
    end
  end

  initial begin
    sb = new();
    item_count = 0;
    idle_cycles = 0;
    now_t = 32'd1000;
    time_span = 32'd100;
    gaps_on = 1;
    stalls_on = 1;
    pressure_hold = 0;
    rst_n          <= 0;
    in_valid       <= 0;
    in_cmd         <= 0;
    in_on_ground   <= 0;
    in_gravity_z   <= '0;
    in_roll_stick  <= '0;
    in_pitch_stick <= '0;
    in_now_us      <= '0;
    psel           <= 0;
    penable        <= 0;
    pwrite         <= 0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed part, full throttle and a short timeout
    set_config(32'd100, 32'd300);
    send_beat(0, 0, -16384, 0, 0, 32'd1000);          // step while disarmed
    send_beat(1, 0, 0, 0, 0, 32'd1000);               // start request airborne
    send_beat(1, 1, 0, 0, 0, 32'd1000);               // arms
    send_beat(1, 1, 0, 0, 0, 32'd1000);               // start request while armed
    send_beat(0, 1, -16384, 0, 0, 32'd1000);
    send_beat(0, 0, -1, 8192, -8192, 32'd1000);       // lift-off inverted, sticks at half
    send_beat(0, 0, -1, 12000, -12000, 32'd1010);     // equal magnitudes pick roll
    send_beat(0, 0, 8192, 0, 0, 32'd1110);            // exactly half: no exit
    send_beat(0, 0, 0, 16384, 16384, 32'd1310);       // elapsed equals timeout
    send_beat(0, 0, 0, -16384, -16384, 32'd1311);     // timeout back to start
    send_beat(0, 0, -32768, -8193, -16384, 32'd1400); // pitch axis, negative
    send_beat(0, 0, 0, 0, 0, 32'd1450);
    send_beat(0, 0, 8193, 0, 0, 32'd1460);            // upright exit
    send_beat(0, 1, 32767, 16384, -16384, 32'd1470);
    send_beat(1, 1, 0, 0, 0, 32'd1480);
    send_beat(0, 0, -100, 0, 0, 32'd1490);            // no ground edge
    send_beat(0, 1, -100, 0, 0, 32'd1500);
    send_beat(0, 0, 8193, 16384, 0, 32'd1510);        // edge while upright: exit
    send_beat(1, 1, 0, 0, 0, 32'd1520);
    send_beat(0, 1, 0, 0, 0, 32'd1530);
    send_beat(0, 0, -32768, 16384, 0, 32'hFFFF_FFF0);
    send_beat(0, 0, 0, 0, 0, 32'h0000_0010);          // time wraps
    send_beat(0, 0, 0, 0, 0, 32'h0000_0200);
    send_beat(0, 0, 32767, 0, 0, 32'h0000_0210);

    run_phase(32'd0, 32'd0, 110);
    run_phase({25'($urandom), 7'd127}, 32'hFFFF_FFFF, 110);
    drain();
    pressure_hold = 1;
    run_phase({25'($urandom), 7'($urandom_range(1, 99))}, 32'($urandom_range(20, 2000)), 110);
    run_phase(32'd50, trs_pkg::TIMEOUT_RST, 100);
    drain();
    gaps_on = 0;
    stalls_on = 0;
    run_phase({25'($urandom), 7'($urandom_range(0, 127))}, 32'($urandom_range(0, 500)), 100);

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("turtle_recovery_sequencer_core test passed");
    end else begin
      $display("turtle_recovery_sequencer_core test failed");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+src
src/trs_pkg.sv
src/trs_cfg_regs.sv
src/trs_step.sv
src/turtle_recovery_sequencer_core.sv
sim/tb_turtle_recovery_sequencer_core.sv
